// ===== hdl/ism_pkg.sv =====
// Shared constants and types for the interval subscription matcher.
`timescale 1ns / 1ps
`default_nettype none
package ism_pkg;
  localparam int MaxConstraints = 1024;
  localparam int MaxSubs = 256;
  localparam int AttrCount = 64;
  localparam int CIdxW = $clog2(MaxConstraints);
  localparam int CCntW = CIdxW + 1;
  localparam int SIdxW = $clog2(MaxSubs);
  localparam int SCntW = SIdxW + 1;
  localparam int CountW = 11;
  localparam logic [CountW-1:0] Overdrawn = '1;
  localparam logic ReqSub = 1'b0;
  localparam logic ReqPub = 1'b1;

  typedef struct packed {
    logic [5:0] attr;
    logic [31:0] low;
    logic [31:0] high;
    logic [SIdxW-1:0] owner;
  } entry_t;
endpackage
`default_nettype wire

// ===== hdl/ism_store.sv =====
// Constraint store memory, one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module ism_store (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [ism_pkg::CIdxW-1:0]   waddr,
  input  wire ism_pkg::entry_t             wdata,
  input  wire logic [ism_pkg::CIdxW-1:0]   raddr,
  output ism_pkg::entry_t                  rdata
);
  ism_pkg::entry_t mem [ism_pkg::MaxConstraints];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/interval_subscription_matcher.sv =====
// Top level: interval subscription matcher with sequencer and counter memories.
// Constraint item: in_ready stays high for the next item. Closing item: result valid the cycle
// after acceptance; the next item is accepted once the result has been taken. Publication
// pair: per stored constraint a read, a compare and a counter update. Last pair: then per
// stored subscription the zero count and reload, after which the result is valid.
// Reset clears counts and control; memories need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module interval_subscription_matcher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic [5:0]  attribute,
  input  wire logic [31:0] low_value,
  input  wire logic [31:0] high_value,
  input  wire logic [31:0] pub_value,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             result_kind,
  output logic [7:0]       sub_id,
  output logic [8:0]       match_count,
  output logic             status
);
  localparam int CW = ism_pkg::CIdxW;
  localparam int CN = ism_pkg::CCntW;
  localparam int SW = ism_pkg::SIdxW;
  localparam int SN = ism_pkg::SCntW;
  localparam int KW = ism_pkg::CountW;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_CHK, S_UPD, S_SUMRD, S_SUM, S_OUT} state_t;
  state_t state;

  logic [CN-1:0] stored_constraints, open_cnt, scan_i;
  logic [SN-1:0] stored_subs, sum_i;
  logic open_failed;
  logic [5:0] p_attr;
  logic signed [31:0] p_val;
  logic p_last;
  logic [8:0] count;

  logic st_we;
  ism_pkg::entry_t st_wdata, st_rdata;
  logic [CW-1:0] st_raddr;

  logic [KW-1:0] req_mem [ism_pkg::MaxSubs];
  logic [KW-1:0] wc_mem [ism_pkg::MaxSubs];
  logic [KW-1:0] wc_rd, req_rd;
  logic [SW-1:0] wc_raddr, upd_owner;
  logic hit;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign st_raddr = scan_i[CW-1:0];
  assign st_wdata = '{attr: attribute, low: low_value, high: high_value,
                      owner: stored_subs[SW-1:0]};

  logic sub_fail;
  assign sub_fail = open_failed || (stored_subs >= SN'(ism_pkg::MaxSubs))
                    || (stored_constraints >= CN'(ism_pkg::MaxConstraints));
  assign st_we = in_valid && in_ready && req_type == ism_pkg::ReqSub && !sub_fail;

  ism_store u_store (
    .clk(clk), .we(st_we), .waddr(stored_constraints[CW-1:0]), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  assign wc_raddr = (state == S_SUMRD || state == S_SUM) ? sum_i[SW-1:0]
                                                           : st_rdata.owner;

  always_ff @(posedge clk) begin
    wc_rd <= wc_mem[wc_raddr];
    req_rd <= req_mem[wc_raddr];
    if (st_we && last) begin
      req_mem[stored_subs[SW-1:0]] <= KW'(open_cnt + 1'b1);
      wc_mem[stored_subs[SW-1:0]] <= KW'(open_cnt + 1'b1);
    end else if (state == S_UPD && hit) begin
      wc_mem[upd_owner] <= (wc_rd == '0 || wc_rd == ism_pkg::Overdrawn)
                           ? ism_pkg::Overdrawn : wc_rd - 1'b1;
    end else if (state == S_SUM) begin
      wc_mem[sum_i[SW-1:0] - 1'b1] <= req_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      stored_constraints <= '0;
      stored_subs <= '0;
      open_cnt <= '0;
      open_failed <= 1'b0;
      out_valid <= 1'b0;
      scan_i <= '0;
      sum_i <= '0;
      hit <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            if (req_type == ism_pkg::ReqSub) begin
              if (last) begin
                out_valid <= 1'b1;
                result_kind <= 1'b0;
                match_count <= '0;
                if (sub_fail) begin
                  stored_constraints <= stored_constraints - open_cnt;
                  sub_id <= '0;
                  status <= 1'b1;
                end else begin
                  stored_constraints <= stored_constraints + 1'b1;
                  stored_subs <= stored_subs + 1'b1;
                  sub_id <= 8'(stored_subs);
                  status <= 1'b0;
                end
                open_cnt <= '0;
                open_failed <= 1'b0;
              end else begin
                open_failed <= sub_fail;
                if (!sub_fail) begin
                  stored_constraints <= stored_constraints + 1'b1;
                  open_cnt <= open_cnt + 1'b1;
                end
              end
            end else begin
              p_attr <= attribute;
              p_val <= pub_value;
              p_last <= last;
              scan_i <= '0;
              hit <= 1'b0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          hit <= 1'b0;
          if (scan_i >= stored_constraints || p_attr >= 6'(ism_pkg::AttrCount - 1)
              && ism_pkg::AttrCount < 64 && p_attr > 6'(ism_pkg::AttrCount - 1)) begin
            sum_i <= '0;
            count <= '0;
            state <= p_last ? S_SUMRD : S_IDLE;
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          upd_owner <= st_rdata.owner;
          hit <= (SN'(st_rdata.owner) < stored_subs) && st_rdata.attr == p_attr
                 && p_val >= $signed(st_rdata.low) && p_val <= $signed(st_rdata.high);
          scan_i <= scan_i + 1'b1;
          state <= S_UPD;
        end
        S_UPD: begin
          state <= S_SCAN;
        end
        S_SUMRD: begin
          if (sum_i >= stored_subs) begin
            out_valid <= 1'b1;
            result_kind <= 1'b1;
            sub_id <= '0;
            status <= 1'b0;
            match_count <= count;
            state <= S_IDLE;
          end else begin
            sum_i <= sum_i + 1'b1;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          if (wc_rd == '0 && count != 9'h1FF) begin
            count <= count + 1'b1;
          end
          state <= S_SUMRD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
